// ===== rtl/lcdns_pkg.sv =====
package lcdns_pkg;

   localparam logic [1:0] FUNC_CMD   = 2'd0;
   localparam logic [1:0] FUNC_CHAR  = 2'd1;
   localparam logic [1:0] FUNC_MOVE  = 2'd2;
   localparam logic [1:0] FUNC_CLEAR = 2'd3;

   localparam logic [7:0] CMD_SET_ADDR = 8'h80;
   localparam logic [7:0] CMD_ROW1_HOME = 8'hC0;
   localparam logic [7:0] CMD_CLEAR = 8'h01;

   localparam logic [4:0] POS_ROW0 = 5'd0;
   localparam logic [4:0] POS_ROW1 = 5'd16;

   localparam logic [11:0] HOLD_NONE  = 12'd0;
   localparam logic [11:0] HOLD_SHORT = 12'd100;
   localparam logic [11:0] HOLD_LONG  = 12'd1000;
   localparam logic [11:0] HOLD_CLEAR = 12'd3000;

   localparam logic [2:0] STEP_IDLE_PINS = 3'd0;
   localparam logic [2:0] STEP_HI_SETUP  = 3'd1;
   localparam logic [2:0] STEP_HI_RISE   = 3'd2;
   localparam logic [2:0] STEP_HI_FALL   = 3'd3;
   localparam logic [2:0] STEP_LO_SETUP  = 3'd4;
   localparam logic [2:0] STEP_LO_RISE   = 3'd5;
   localparam logic [2:0] STEP_LO_FALL   = 3'd6;

   typedef struct packed {
      logic       has_pre;
      logic [7:0] pre_byte;
      logic [7:0] main_byte;
      logic       is_data;
      logic       is_clear;
   } job_type;

   typedef struct packed {
      logic        rs;
      logic        en;
      logic [3:0]  nib;
      logic [11:0] hold;
   } step_type;

   typedef enum logic [1:0] {
      SEG_IDLE,
      SEG_PRE,
      SEG_MAIN,
      SEG_TAIL
   } seg_type;

   function automatic step_type byte_step(logic [7:0] byte_val, logic is_data,
                                          logic [2:0] idx);
      step_type s;
      s.rs   = 1'b0;
      s.en   = 1'b0;
      s.nib  = 4'h0;
      s.hold = HOLD_NONE;
      case (idx)
         STEP_IDLE_PINS: begin
            s.hold = is_data ? HOLD_NONE : HOLD_LONG;
         end
         STEP_HI_SETUP: begin
            s.nib  = byte_val[7:4];
            s.hold = HOLD_SHORT;
         end
         STEP_HI_RISE: begin
            s.rs   = is_data;
            s.en   = 1'b1;
            s.nib  = byte_val[7:4];
            s.hold = is_data ? HOLD_LONG : HOLD_SHORT;
         end
         STEP_HI_FALL: begin
            s.rs   = is_data;
            s.nib  = byte_val[7:4];
            s.hold = HOLD_SHORT;
         end
         STEP_LO_SETUP: begin
            s.rs   = is_data;
            s.nib  = byte_val[3:0];
            s.hold = HOLD_SHORT;
         end
         STEP_LO_RISE: begin
            s.rs   = is_data;
            s.en   = 1'b1;
            s.nib  = byte_val[3:0];
            s.hold = HOLD_SHORT;
         end
         STEP_LO_FALL: begin
            s.rs   = is_data;
            s.nib  = byte_val[3:0];
            s.hold = is_data ? HOLD_NONE : HOLD_SHORT;
         end
         default: begin
            s.hold = HOLD_NONE;
         end
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/lcdns_req_if.sv =====
interface lcdns_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] code_byte;
   logic [3:0] col;
   logic       row;

   modport source (output valid, func, code_byte, col, row, input ready);
   modport sink (input valid, func, code_byte, col, row, output ready);
endinterface

// ===== rtl/lcdns_rsp_if.sv =====
interface lcdns_rsp_if;
   logic        valid;
   logic        ready;
   logic        reg_select;
   logic        read_write;
   logic        enable;
   logic [3:0]  data_nibble;
   logic [11:0] hold_us;
   logic        last;

   modport source (output valid, reg_select, read_write, enable, data_nibble, hold_us, last,
                   input ready);
   modport sink (input valid, reg_select, read_write, enable, data_nibble, hold_us, last,
                 output ready);
endinterface

// ===== rtl/lcdns_front.sv =====
module lcdns_front (
   input  logic                clock,
   input  logic                reset,
   lcdns_req_if.sink           req_if,
   input  logic                q_full,
   output logic                q_push,
   output lcdns_pkg::job_type  q_job
);
   import lcdns_pkg::*;

   logic [4:0] cursor_ff;
   logic [4:0] cursor_in;
   logic       accept;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;
   assign q_push       = accept;

   always_comb begin
      cursor_in        = cursor_ff;
      q_job.has_pre    = 1'b0;
      q_job.pre_byte   = CMD_SET_ADDR;
      q_job.main_byte  = req_if.code_byte;
      q_job.is_data    = 1'b0;
      q_job.is_clear   = 1'b0;
      case (req_if.func)
         FUNC_CMD: begin
            q_job.main_byte = req_if.code_byte;
         end
         FUNC_CHAR: begin
            // row change before the character when the cursor sits at a row start
            if (cursor_ff == POS_ROW1) begin
               q_job.has_pre  = 1'b1;
               q_job.pre_byte = CMD_ROW1_HOME;
            end else if (cursor_ff == POS_ROW0) begin
               q_job.has_pre  = 1'b1;
               q_job.pre_byte = CMD_SET_ADDR;
            end
            q_job.is_data = 1'b1;
            cursor_in     = cursor_ff + 5'd1;
         end
         FUNC_MOVE: begin
            q_job.main_byte = {1'b1, req_if.row, 2'b00, req_if.col};
            cursor_in       = {req_if.row, req_if.col};
         end
         FUNC_CLEAR: begin
            q_job.main_byte = CMD_CLEAR;
            q_job.is_clear  = 1'b1;
            cursor_in       = POS_ROW0;
         end
         default: begin
            q_job.main_byte = req_if.code_byte;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= POS_ROW0;
      end else if (accept) begin
         cursor_ff <= cursor_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_clear_homes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.func == FUNC_CLEAR) |=> (cursor_ff == POS_ROW0))
      else $error("cursor not cleared after clear transaction");
`endif

endmodule

// ===== rtl/lcdns_fifo.sv =====
module lcdns_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lcdns_pkg::job_type  push_job,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output lcdns_pkg::job_type  head_job
);
   import lcdns_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff;
   logic [AW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");
`endif

endmodule

// ===== rtl/lcdns_back.sv =====
module lcdns_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  lcdns_pkg::job_type  q_job,
   output logic                q_pop,
   lcdns_rsp_if.source         rsp_if
);
   import lcdns_pkg::*;

   seg_type     state_ff;
   seg_type     state_in;
   logic [2:0]  step_ff;
   logic [2:0]  step_in;
   job_type     job_ff;
   job_type     job_in;

   logic        out_valid_ff;
   logic        out_valid_in;
   step_type    out_step_ff;
   logic        out_last_ff;

   step_type    cur_step;
   logic        cur_last;
   logic        advance;
   logic        pop;

   // outputs: current pin step, handshake with the output register
   always_comb begin
      advance = (state_ff != SEG_IDLE) && (!out_valid_ff || rsp_if.ready);
      case (state_ff)
         SEG_PRE: begin
            cur_step = byte_step(job_ff.pre_byte, 1'b0, step_ff);
            cur_last = 1'b0;
         end
         SEG_MAIN: begin
            cur_step = byte_step(job_ff.main_byte, job_ff.is_data, step_ff);
            cur_last = (step_ff == STEP_LO_FALL) && !job_ff.is_clear;
         end
         SEG_TAIL: begin
            // clear execution wait repeats the final pin state
            cur_step      = byte_step(CMD_CLEAR, 1'b0, STEP_LO_FALL);
            cur_step.hold = HOLD_CLEAR;
            cur_last      = 1'b1;
         end
         default: begin
            cur_step = byte_step(job_ff.main_byte, 1'b0, STEP_IDLE_PINS);
            cur_last = 1'b0;
         end
      endcase
      pop          = q_valid && ((state_ff == SEG_IDLE) || (advance && cur_last));
      out_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);
   end

   assign q_pop = pop;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      job_in   = job_ff;
      if (pop) begin
         job_in   = q_job;
         state_in = q_job.has_pre ? SEG_PRE : SEG_MAIN;
         step_in  = STEP_IDLE_PINS;
      end else begin
         case (state_ff)
            SEG_IDLE: begin
               state_in = SEG_IDLE;
            end
            SEG_PRE: begin
               if (advance) begin
                  if (step_ff == STEP_LO_FALL) begin
                     state_in = SEG_MAIN;
                     step_in  = STEP_IDLE_PINS;
                  end else begin
                     step_in = step_ff + 3'd1;
                  end
               end
            end
            SEG_MAIN: begin
               if (advance) begin
                  if (step_ff == STEP_LO_FALL) begin
                     state_in = job_ff.is_clear ? SEG_TAIL : SEG_IDLE;
                     step_in  = STEP_IDLE_PINS;
                  end else begin
                     step_in = step_ff + 3'd1;
                  end
               end
            end
            SEG_TAIL: begin
               if (advance) begin
                  state_in = SEG_IDLE;
               end
            end
            default: begin
               state_in = SEG_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEG_IDLE;
         step_ff      <= STEP_IDLE_PINS;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (advance) begin
         out_step_ff <= cur_step;
         out_last_ff <= cur_last;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.reg_select  = out_step_ff.rs;
   assign rsp_if.read_write  = 1'b0;
   assign rsp_if.enable      = out_step_ff.en;
   assign rsp_if.data_nibble = out_step_ff.nib;
   assign rsp_if.hold_us     = out_step_ff.hold;
   assign rsp_if.last        = out_last_ff;

`ifndef NO_ASSERTIONS
   a_last_enable_low: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> !out_step_ff.en)
      else $error("final step leaves the enable strobe high");
   a_pop_at_boundary: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> ((state_ff == SEG_IDLE) || cur_last))
      else $error("new job taken in the middle of a byte");
`endif

endmodule

// ===== rtl/char_lcd_nibble_write_sequencer_core.sv =====
// channel   dir  handshake               payload
// req_if    in   req_if.valid/ready      func, code_byte, col, row
// rsp_if    out  rsp_if.valid/ready      reg_select, read_write, enable, data_nibble,
//                                        hold_us, last
//
// one pin step leaves per cycle while rsp_if is ready; a transaction yields 7, 8 or 14 steps
// the output step rate is set by the single sequencer in the back end
// the front end takes a transaction per cycle until the job queue is full
// synchronous active-high reset clears cursor, queue and sequencer
// a stalled rsp_if holds its step while the front keeps filling the queue
module char_lcd_nibble_write_sequencer_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   lcdns_req_if.sink  req_if,
   lcdns_rsp_if.source rsp_if
);
   import lcdns_pkg::*;

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   job_type push_job;
   job_type head_job;

   lcdns_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (push_job)
   );

   lcdns_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_job  (head_job)
   );

   lcdns_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (head_job),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule
